[rtl/afsc_pkg.sv]
// ----------------------------------------------------------------------------
// afsc_pkg: shared types and constants of the adaptive frame-skip controller
// Item and configuration records, operation and decision codes, and the
// small constant-division helpers used by the execution unit.
// ----------------------------------------------------------------------------
package afsc_pkg;

  localparam int SkipSetW = 9;
  localparam int SkipW    = 8;
  localparam int ElapsedW = 24;
  localparam int TimeW    = 48;
  localparam int AvgW     = 32;
  localparam int AccW     = 36;
  localparam int ProdW    = 48;
  localparam int FdivW    = 34;
  localparam int QuotW    = 14;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int DecW     = 3;

  // The divide by ten of the average update works on 18-bit digits, so the
  // 36-bit sum takes two steps. Each step divides the running remainder and
  // the next digit by reciprocal multiplication.
  localparam int                  Div10DigW  = 18;
  localparam int                  Div10InW   = Div10DigW + 4;
  localparam int                  Div10Steps = AccW / Div10DigW;
  localparam logic [Div10InW-1:0] Div10Recip = 22'd3355444;
  localparam int                  Div10Shift = 25;

  // One frame period in microseconds scaled by 0.9 and by 2^16 handled apart.
  localparam logic [FdivW-1:0] FrameDiv      = 34'd900000;
  localparam logic [FdivW-1:0] FrameDivRound = FrameDiv - 34'd1;

  // 900000 = 2^5 * 28125: the dividend drops five bits, and the division by
  // 28125 is a multiply by ceil(2^43 / 28125) followed by a shift by 43.
  localparam int                FrameDivShift   = 5;
  localparam int                RecipW          = FdivW - FrameDivShift;
  localparam int                FrameProdW      = 2 * RecipW;
  localparam logic [RecipW-1:0] FrameRecip      = 29'd312749975;
  localparam int                FrameRecipShift = 43;

  localparam logic signed [SkipSetW-1:0] RstSkipSetting = -9'sd1;
  localparam logic [15:0]                RstOutputFps   = 16'd7680;
  localparam logic [SkipW-1:0]           RstMinSkip     = 8'd0;
  localparam logic [15:0]                RstEvalMs      = 16'd1000;
  localparam logic [15:0]                RstHoldMs      = 16'd5000;

  typedef enum logic [1:0] {
    OP_SAMPLE   = 2'd0,
    OP_DISABLED = 2'd1,
    OP_STATIC   = 2'd2,
    OP_AUTO     = 2'd3
  } op_t;

  typedef enum logic [DecW-1:0] {
    DEC_SAMPLE   = 3'd0,
    DEC_DISABLED = 3'd1,
    DEC_STATIC   = 3'd2,
    DEC_NOT_DUE  = 3'd3,
    DEC_RAISED   = 3'd4,
    DEC_LOWERED  = 3'd5,
    DEC_HOLD     = 3'd6
  } decision_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SKIP_SETTING = 3'd0,
    REG_OUTPUT_FPS   = 3'd1,
    REG_MIN_SKIP     = 3'd2,
    REG_EVAL_MS      = 3'd3,
    REG_HOLD_MS      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SkipSetW-1:0] skip_setting;
    logic [15:0]                output_fps;
    logic [SkipW-1:0]           min_skip;
    logic [15:0]                eval_interval_ms;
    logic [15:0]                hold_interval_ms;
  } cfg_t;

  typedef struct packed {
    op_t                 op;
    logic [ElapsedW-1:0] elapsed_us;
    logic [TimeW-1:0]    now_ms;
    logic [SkipW-1:0]    static_skip;
  } item_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

  // Quotient digit of x/10 for x below 10 * 2^18, by reciprocal multiplication.
  function automatic logic [Div10DigW-1:0] div10_digit(input logic [Div10InW-1:0] x);
    logic [2*Div10InW-1:0] p;
    p = {{Div10InW{1'b0}}, x} * {{Div10InW{1'b0}}, Div10Recip};
    return p[Div10Shift +: Div10DigW];
  endfunction

  // x/5 for any 8-bit x, by reciprocal multiplication.
  function automatic logic [SkipW-1:0] div5(input logic [SkipW-1:0] x);
    logic [25:0] p;
    p = 26'(x) * 26'd52429;
    return p[25:18];
  endfunction

endpackage

[rtl/afsc_if.sv]
// ----------------------------------------------------------------------------
// afsc_if: channel interfaces of the adaptive frame-skip controller
// Item input, result output and configuration write channels, each with
// valid/ready and a source and a sink view.
// ----------------------------------------------------------------------------
interface afsc_in_if;
  import afsc_pkg::*;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [ElapsedW-1:0] elapsed_us;
  logic [TimeW-1:0]    now_ms;
  modport source (output valid, kind, elapsed_us, now_ms, input ready);
  modport sink (input valid, kind, elapsed_us, now_ms, output ready);
endinterface

interface afsc_out_if;
  import afsc_pkg::*;
  logic                valid;
  logic                ready;
  logic [SkipW-1:0]    skip_count;
  logic                changed;
  logic [DecW-1:0]     decision;
  logic [ElapsedW-1:0] avg_time_us;
  modport source (output valid, skip_count, changed, decision, avg_time_us, input ready);
  modport sink (input valid, skip_count, changed, decision, avg_time_us, output ready);
endinterface

interface afsc_cfg_if;
  import afsc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/afsc_front.sv]
// ----------------------------------------------------------------------------
// afsc_front: item intake and classification
// Accepts item beats while the queue has room and tags each one with the
// operation the execution unit must perform under the current mode.
// ----------------------------------------------------------------------------
module afsc_front (
  input  afsc_pkg::cfg_t      cfg,
  input  afsc_pkg::q_status_t q_status,
  afsc_in_if.sink             items,
  output logic                push,
  output afsc_pkg::item_t     item
);
  import afsc_pkg::*;

  assign items.ready = !q_status.full;
  assign push        = items.valid && !q_status.full;

  always_comb begin
    item.elapsed_us  = items.elapsed_us;
    item.now_ms      = items.now_ms;
    item.static_skip = cfg.skip_setting[SkipW-1:0];
    if (items.kind == 1'b0) begin
      item.op = OP_SAMPLE;
    end else if (cfg.skip_setting[SkipSetW-1]) begin
      item.op = OP_DISABLED;
    end else if (cfg.skip_setting == '0) begin
      item.op = OP_AUTO;
    end else begin
      item.op = OP_STATIC;
    end
  end

endmodule

[rtl/afsc_queue.sv]
// ----------------------------------------------------------------------------
// afsc_queue: two-entry item queue
// Decouples intake from execution so that either side can stall alone.
// ----------------------------------------------------------------------------
module afsc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  afsc_pkg::item_t     item,
  input  logic                pop,
  output afsc_pkg::q_status_t q_status,
  output afsc_pkg::item_t     head
);
  import afsc_pkg::*;

  item_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign q_status.full  = (count == 2'd2);
  assign q_status.valid = (count != 2'd0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && q_status.valid;
  assign head           = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= item;
    end
  end

endmodule

[rtl/afsc_back.sv]
// ----------------------------------------------------------------------------
// afsc_back: execution unit
// Runs one item at a time: the moving-average update with a two-step
// divide by ten, or the skip decision with a multiply and a reciprocal
// multiply for the frame constant, then loads the result register.
// ----------------------------------------------------------------------------
module afsc_back (
  input  logic            clk,
  input  logic            rst,
  input  afsc_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  afsc_pkg::item_t q_item,
  output logic            q_pop,
  afsc_out_if.source      results
);
  import afsc_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_DIV10 = 9'b000000010,
    ST_CHECK = 9'b000000100,
    ST_MUL   = 9'b000001000,
    ST_LOAD  = 9'b000010000,
    ST_DIVF  = 9'b000100000,
    ST_CLAMP = 9'b001000000,
    ST_APPLY = 9'b010000000,
    ST_EMIT  = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  // Architectural state.
  logic [AvgW-1:0]  avg_q;
  logic [SkipW-1:0] skip_value;
  logic [TimeW-1:0] last_check;
  logic [TimeW-1:0] last_change;
  logic             started;

  // Working registers.
  logic [TimeW-1:0]   now_ms;
  logic [SkipW-1:0]   skip_before;
  decision_t          decision;
  logic [AccW-1:0]    acc;
  logic [3:0]         rem;
  logic [3:0]         cnt;
  logic [ProdW-1:0]   prod;
  logic [FdivW-1:0]   frem;
  logic [QuotW-1:0]   fq;
  logic signed [9:0]  nxt;
  logic signed [9:0]  lim;
  logic               hold_ok;

  // Output register.
  logic                out_valid;
  logic [SkipW-1:0]    out_skip;
  logic                out_changed;
  logic [DecW-1:0]     out_decision;
  logic [ElapsedW-1:0] out_avg;

  logic                  out_free;
  logic                  emit;
  logic [AccW-1:0]       sample_acc;
  logic [Div10InW-1:0]   dig_x;
  logic [Div10DigW-1:0]  dig_q;
  logic [Div10InW-1:0]   dig_r;
  logic [AccW-1:0]       acc_shift;
  logic [TimeW-1:0]      eff_check;
  logic [TimeW-1:0]      eff_change;
  logic [TimeW-1:0]      el_check;
  logic [TimeW-1:0]      el_stable;
  logic                  due;
  logic                  no_work;
  logic [FdivW-1:0]      frem_load;
  logic [FrameProdW-1:0] frame_p;
  logic [7:0]            fps_int;
  logic signed [9:0]     mins_s;
  logic signed [9:0]     raw_next;
  logic signed [9:0]     clamp_next;
  logic [SkipW-1:0]      step;
  logic [SkipW-1:0]      step_eff;
  logic signed [9:0]     skip_s;
  logic signed [9:0]     low_a;
  logic signed [9:0]     lower_val;

  assign out_free = !out_valid || results.ready;
  assign emit     = (state == ST_EMIT) && out_free;
  assign q_pop    = (state == ST_IDLE) && q_valid;

  assign results.valid       = out_valid;
  assign results.skip_count  = out_skip;
  assign results.changed     = out_changed;
  assign results.decision    = out_decision;
  assign results.avg_time_us = out_avg;

  // avg*9 + sample*256, ahead of the divide by ten.
  assign sample_acc = ({4'b0, avg_q} << 3) + {4'b0, avg_q} + {4'b0, q_item.elapsed_us, 8'b0};

  // One 18-bit quotient digit per cycle; the quotient shifts in behind.
  assign dig_x     = {rem, acc[AccW-1 -: Div10DigW]};
  assign dig_q     = div10_digit(dig_x);
  assign dig_r     = dig_x - Div10InW'(dig_q) * Div10InW'(4'd10);
  assign acc_shift = {acc[AccW-Div10DigW-1:0], dig_q};

  assign eff_check  = started ? last_check : now_ms;
  assign eff_change = started ? last_change : now_ms;
  assign el_check   = now_ms - eff_check;
  assign el_stable  = now_ms - eff_change;
  assign due        = el_check > {32'b0, cfg.eval_interval_ms};
  assign no_work    = (avg_q == '0) || (cfg.output_fps == '0);

  // ceil(prod / 2^16) + FrameDiv - 1, so a floor divide gives the ceiling.
  assign frem_load = {2'b0, prod[ProdW-1:16]} + FdivW'(prod[15:0] != 16'd0) + FrameDivRound;

  // The dividend is below 2^33, so after dropping five bits it is below
  // 2^28, where the reciprocal for 28125 gives the exact floor.
  assign frame_p = {{RecipW{1'b0}}, frem[FdivW-1:FrameDivShift]} *
                   {{RecipW{1'b0}}, FrameRecip};

  assign fps_int    = cfg.output_fps[15:8];
  assign mins_s     = $signed({2'b0, cfg.min_skip});
  assign raw_next   = $signed({2'b0, fq[7:0]}) - 10'sd1;
  always_comb begin
    if (fq > {6'b0, fps_int}) begin
      clamp_next = $signed({2'b0, fps_int}) - 10'sd1;
    end else if (raw_next < mins_s) begin
      clamp_next = mins_s;
    end else begin
      clamp_next = raw_next;
    end
  end

  assign step      = div5(skip_value);
  assign step_eff  = (step == '0) ? 8'd1 : step;
  assign skip_s    = $signed({2'b0, skip_value});
  assign low_a     = (lim > nxt) ? lim : nxt;
  assign lower_val = (low_a < mins_s) ? mins_s : low_a;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_item.op)
            OP_SAMPLE:   state_next = ST_DIV10;
            OP_DISABLED: state_next = ST_EMIT;
            OP_STATIC:   state_next = ST_EMIT;
            OP_AUTO:     state_next = ST_CHECK;
          endcase
        end
      end
      ST_DIV10: begin
        if (cnt == 4'd0) begin
          state_next = ST_EMIT;
        end
      end
      ST_CHECK: begin
        if (!due || no_work) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:   state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_DIVF;
      ST_DIVF:  state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_APPLY;
      ST_APPLY: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      avg_q       <= '0;
      skip_value  <= '0;
      last_check  <= '0;
      last_change <= '0;
      started     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_IDLE && q_valid && q_item.op == OP_STATIC) begin
        skip_value <= q_item.static_skip;
      end
      if (state == ST_DIV10 && cnt == 4'd0) begin
        avg_q <= acc_shift[AvgW-1:0];
      end
      if (state == ST_CHECK) begin
        if (!started) begin
          started     <= 1'b1;
          last_check  <= now_ms;
          last_change <= now_ms;
        end
        if (due) begin
          last_check <= now_ms;
        end
      end
      if (state == ST_APPLY) begin
        if (skip_s < nxt) begin
          skip_value  <= nxt[SkipW-1:0];
          last_change <= now_ms;
        end else if (skip_s > nxt && hold_ok) begin
          skip_value  <= lower_val[SkipW-1:0];
          last_change <= now_ms;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        now_ms      <= q_item.now_ms;
        skip_before <= skip_value;
        acc         <= sample_acc;
        rem         <= 4'd0;
        cnt         <= 4'(Div10Steps - 1);
        if (q_item.op == OP_DISABLED) begin
          decision <= DEC_DISABLED;
        end else begin
          decision <= DEC_STATIC;
        end
      end
      ST_DIV10: begin
        acc      <= acc_shift;
        rem      <= dig_r[3:0];
        cnt      <= cnt - 4'd1;
        decision <= DEC_SAMPLE;
      end
      ST_CHECK: begin
        hold_ok <= el_stable > {32'b0, cfg.hold_interval_ms};
        if (!due) begin
          decision <= DEC_NOT_DUE;
        end else begin
          decision <= DEC_HOLD;
        end
      end
      ST_MUL: begin
        prod <= {32'b0, cfg.output_fps} * {16'b0, avg_q};
      end
      ST_LOAD: begin
        frem <= frem_load;
      end
      ST_DIVF: begin
        fq <= frame_p[FrameRecipShift +: QuotW];
      end
      ST_CLAMP: begin
        nxt <= clamp_next;
        lim <= skip_s - $signed({2'b0, step_eff});
      end
      ST_APPLY: begin
        if (skip_s < nxt) begin
          decision <= DEC_RAISED;
        end else if (skip_s > nxt && hold_ok) begin
          decision <= DEC_LOWERED;
        end else begin
          decision <= DEC_HOLD;
        end
      end
      default: begin
      end
    endcase
    if (emit) begin
      out_skip     <= skip_value;
      out_changed  <= skip_value != skip_before;
      out_decision <= decision;
      out_avg      <= avg_q[AvgW-1:8];
    end
  end

endmodule

[rtl/adaptive_frame_skip_controller_core.sv]
// ----------------------------------------------------------------------------
// adaptive_frame_skip_controller_core: adaptive frame-skip controller
// Tracks a moving average of per-frame processing time and decides how
// many frames to skip so that processing keeps up with the output rate.
// ----------------------------------------------------------------------------
//
//  Channel   Role  Beat contents
//  --------  ----  ---------------------------------------------------------
//  items     sink  kind, elapsed_us (sample), now_ms (evaluation)
//  results   src   skip_count, changed, decision, avg_time_us (one per item)
//  cfg       sink  index, data (register write, always ready)
//
//  A sample runs the two 18-bit digit steps of the divide by ten. A due
//  automatic evaluation steps through check, multiply, ceiling, reciprocal
//  divide, clamp, apply and the result load. Disabled and static evaluations
//  go straight to the result load, and evaluations that are not due or have
//  nothing to compute go from the check straight to the result load.
//  Reset clears the control state and loads the register defaults. A
//  two-entry queue and the result register let intake continue while a
//  finished result waits to be taken.
//
module adaptive_frame_skip_controller_core (
  input logic        clk,
  input logic        rst,
  afsc_in_if.sink    items,
  afsc_out_if.source results,
  afsc_cfg_if.sink   cfg
);
  import afsc_pkg::*;

  // Configuration registers. Writes must arrive only while the block is idle;
  // the block itself does not enforce this. Every stage may read them directly.
  cfg_t      cfg_regs;
  cfg_reg_t  cfg_sel;

  // Handoff between the intake and the execution unit.
  q_status_t q_status;
  logic      push;
  item_t     item;
  item_t     head;
  logic      pop;

  assign cfg.ready = 1'b1;
  assign cfg_sel   = cfg_reg_t'(cfg.index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.skip_setting     <= RstSkipSetting;
      cfg_regs.output_fps       <= RstOutputFps;
      cfg_regs.min_skip         <= RstMinSkip;
      cfg_regs.eval_interval_ms <= RstEvalMs;
      cfg_regs.hold_interval_ms <= RstHoldMs;
    end else if (cfg.valid) begin
      unique case (cfg_sel)
        REG_SKIP_SETTING: cfg_regs.skip_setting     <= $signed(cfg.data[SkipSetW-1:0]);
        REG_OUTPUT_FPS:   cfg_regs.output_fps       <= cfg.data;
        REG_MIN_SKIP:     cfg_regs.min_skip         <= cfg.data[SkipW-1:0];
        REG_EVAL_MS:      cfg_regs.eval_interval_ms <= cfg.data;
        REG_HOLD_MS:      cfg_regs.hold_interval_ms <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // The front end tags each item beat with the work it needs under the
  // mode in force when it arrives.
  afsc_front u_front (
    .cfg      (cfg_regs),
    .q_status (q_status),
    .items    (items),
    .push     (push),
    .item     (item)
  );

  afsc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .pop      (pop),
    .q_status (q_status),
    .head     (head)
  );

  // The back end owns the average, the skip count and both timers, and
  // finishes each item by loading the result register.
  afsc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_regs),
    .q_valid (q_status.valid),
    .q_item  (head),
    .q_pop   (pop),
    .results (results)
  );

  // No result beat may be pending in the cycle after reset.
  a_no_result_after_reset: assert property (
    @(posedge clk) disable iff (rst) $past(rst) |-> !results.valid
  ) else $error("result beat pending right after reset");

  // Only static, raised and lowered decisions can change the skip count.
  a_change_needs_cause: assert property (
    @(posedge clk) disable iff (rst)
    (results.valid && results.changed) |->
      (results.decision == DEC_STATIC || results.decision == DEC_RAISED ||
       results.decision == DEC_LOWERED)
  ) else $error("skip count changed without a changing decision");

  // A lowering never goes below the configured minimum.
  a_lower_respects_min: assert property (
    @(posedge clk) disable iff (rst)
    (results.valid && results.decision == DEC_LOWERED) |->
      (results.skip_count >= cfg_regs.min_skip)
  ) else $error("lowered skip count below the minimum");

endmodule

[bench/afsc_tb_pkg.sv]
// ----------------------------------------------------------------------------
// afsc_tb_pkg: bench-side codes for the frame-skip controller testbench
// Item kind codes shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package afsc_tb_pkg;

  localparam logic KindSample = 1'b0;
  localparam logic KindEval   = 1'b1;

endpackage

[bench/afsc_checker.sv]
// ----------------------------------------------------------------------------
// afsc_checker: result checker of the adaptive frame-skip controller
// Watches the item, result and register channels, keeps its own copy of the
// averaging and skip state, and compares every result beat in order.
// ----------------------------------------------------------------------------
module afsc_checker
  import afsc_pkg::*;
  import afsc_tb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  afsc_in_if   items,
  afsc_out_if  results,
  afsc_cfg_if  cfg,
  output int   errors,
  output int   pending
);

  // 900000 us per frame at unit rate, times 2^16 for the Q8.8 rate and Q24.8 average.
  localparam logic [63:0] FrameDivQ = 64'd58982400000;

  typedef struct packed {
    logic [SkipW-1:0]    skip_count;
    logic                changed;
    decision_t           decision;
    logic [ElapsedW-1:0] avg_time_us;
  } skip_report_t;

  logic signed [SkipSetW-1:0] mode_setting;
  logic [15:0]                fps_q;
  logic [SkipW-1:0]           skip_floor;
  logic [15:0]                eval_ms;
  logic [15:0]                hold_ms;

  logic [AvgW-1:0]  avg_q;
  logic [SkipW-1:0] skip_now;
  logic [TimeW-1:0] last_eval_ms;
  logic [TimeW-1:0] last_move_ms;
  logic             timers_on;

  skip_report_t reports_due[$];

  function automatic decision_t auto_decide(input logic [TimeW-1:0] now);
    logic [TimeW-1:0] since_eval;
    logic [TimeW-1:0] since_move;
    logic [63:0]      prod;
    logic [63:0]      ceil_q;
    int               need;
    int               cur;
    int               step;
    int               lim;
    if (!timers_on) begin
      last_eval_ms = now;
      last_move_ms = now;
      timers_on    = 1'b1;
    end
    since_eval = now - last_eval_ms;
    since_move = now - last_move_ms;
    if (since_eval <= TimeW'(eval_ms)) return DEC_NOT_DUE;
    last_eval_ms = now;
    if (avg_q == '0 || fps_q == '0) return DEC_HOLD;
    prod   = 64'(fps_q) * 64'(avg_q);
    ceil_q = (prod + FrameDivQ - 64'd1) / FrameDivQ;
    need   = int'(ceil_q) - 1;
    // The top clamp is floor(fps) - 1, which is -1 below one frame per second.
    if (ceil_q * 64'd256 > 64'(fps_q)) need = int'(fps_q >> 8) - 1;
    else if (need < int'(skip_floor)) need = int'(skip_floor);
    cur = int'(skip_now);
    if (cur < need) begin
      skip_now     = SkipW'(need);
      last_move_ms = now;
      return DEC_RAISED;
    end
    if (cur > need && since_move > TimeW'(hold_ms)) begin
      step = (cur / 5 < 1) ? 1 : cur / 5;
      lim  = cur - step;
      if (lim > need) need = lim;
      if (need < int'(skip_floor)) need = int'(skip_floor);
      skip_now     = SkipW'(need);
      last_move_ms = now;
      return DEC_LOWERED;
    end
    return DEC_HOLD;
  endfunction

  function automatic skip_report_t apply_item(input logic kind,
                                              input logic [ElapsedW-1:0] us,
                                              input logic [TimeW-1:0] now);
    skip_report_t     r;
    logic [SkipW-1:0] prior;
    logic [63:0]      acc;
    prior = skip_now;
    if (kind == KindSample) begin
      acc   = 64'(avg_q) * 64'd9 + (64'(us) << 8);
      avg_q = AvgW'(acc / 64'd10);
      r.decision = DEC_SAMPLE;
    end else if (mode_setting < 0) begin
      r.decision = DEC_DISABLED;
    end else if (mode_setting > 0) begin
      skip_now   = SkipW'(mode_setting);
      r.decision = DEC_STATIC;
    end else begin
      r.decision = auto_decide(now);
    end
    r.skip_count  = skip_now;
    r.changed     = (skip_now != prior);
    r.avg_time_us = avg_q[AvgW-1:8];
    return r;
  endfunction

  task automatic report_miss(input string why, input skip_report_t want,
                             input skip_report_t got);
    errors++;
    if (errors <= 10)
      $display("%0t %s: expected skip=%0d changed=%0d decision=%0d avg=%0d, got skip=%0d changed=%0d decision=%0d avg=%0d",
               $time, why, want.skip_count, want.changed, want.decision, want.avg_time_us,
               got.skip_count, got.changed, got.decision, got.avg_time_us);
  endtask

  always @(posedge clk) begin
    skip_report_t want;
    skip_report_t got;
    if (rst) begin
      mode_setting = RstSkipSetting;
      fps_q        = RstOutputFps;
      skip_floor   = RstMinSkip;
      eval_ms      = RstEvalMs;
      hold_ms      = RstHoldMs;
      avg_q        = '0;
      skip_now     = '0;
      last_eval_ms = '0;
      last_move_ms = '0;
      timers_on    = 1'b0;
      reports_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          REG_SKIP_SETTING: mode_setting = cfg.data[SkipSetW-1:0];
          REG_OUTPUT_FPS:   fps_q = cfg.data;
          REG_MIN_SKIP:     skip_floor = cfg.data[SkipW-1:0];
          REG_EVAL_MS:      eval_ms = cfg.data;
          REG_HOLD_MS:      hold_ms = cfg.data;
          default: ;
        endcase
      end
      if (results.valid && results.ready) begin
        got.skip_count  = results.skip_count;
        got.changed     = results.changed;
        got.decision    = decision_t'(results.decision);
        got.avg_time_us = results.avg_time_us;
        if (reports_due.size() == 0) begin
          report_miss("result beat with nothing expected", '0, got);
        end else begin
          want = reports_due.pop_front();
          if (got.skip_count !== want.skip_count || got.changed !== want.changed ||
              got.decision !== want.decision || got.avg_time_us !== want.avg_time_us)
            report_miss("result mismatch", want, got);
        end
      end
      if (items.valid && items.ready)
        reports_due.push_back(apply_item(items.kind, items.elapsed_us, items.now_ms));
    end
    pending <= reports_due.size();
  end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench of the adaptive frame-skip controller
// Drives sample and evaluation beats through a directed opening and a set
// of randomized register settings, with random gaps on both channels and
// one long result stall; a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;
  import afsc_pkg::*;
  import afsc_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending;

  // Burst flags turn the random gaps off for a while on each side, so the
  // run has stretches where beats go back to back.
  bit          send_burst = 1'b0;
  bit          take_burst = 1'b0;
  int unsigned taken = 0;

  afsc_in_if  items ();
  afsc_out_if results ();
  afsc_cfg_if cfg ();

  adaptive_frame_skip_controller_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results),
    .cfg     (cfg)
  );

  afsc_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results),
    .cfg     (cfg),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the block hangs; well beyond the slowest correct run.
  initial begin
    #800000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Gap before the next beat on one side; occasionally flips burst mode.
  function automatic int draw_gap(ref bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 14);
  endfunction

  // Offers one item and returns at the edge where it is accepted. valid is
  // left high so that a back-to-back item needs no second assignment.
  task automatic send_item(input logic kind, input logic [ElapsedW-1:0] us,
                           input logic [TimeW-1:0] now);
    int gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      items.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items.valid      <= 1'b1;
    items.kind       <= kind;
    items.elapsed_us <= us;
    items.now_ms     <= now;
    do @(posedge clk); while (!items.ready);
  endtask

  // Waits until every expected result has been taken, then lets the block's
  // longest operation run out before anything else.
  task automatic drain;
    items.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Writes all five registers back to back; only called while idle.
  task automatic configure(input logic signed [SkipSetW-1:0] mode,
                           input logic [15:0] fps,
                           input logic [SkipW-1:0] floor_skip,
                           input logic [15:0] eval_ms,
                           input logic [15:0] hold_ms);
    cfg_reg_t            regs[5];
    logic [CfgDataW-1:0] vals[5];
    regs = '{REG_SKIP_SETTING, REG_OUTPUT_FPS, REG_MIN_SKIP, REG_EVAL_MS, REG_HOLD_MS};
    vals = '{{7'd0, mode}, fps, {8'd0, floor_skip}, eval_ms, hold_ms};
    for (int i = 0; i < 5; i++) begin
      cfg.valid <= 1'b1;
      cfg.index <= regs[i];
      cfg.data  <= vals[i];
      do @(posedge clk); while (!cfg.ready);
    end
    cfg.valid <= 1'b0;
  endtask

  // Result side: random stalls, plus one long hold-off while the sender keeps
  // offering, so the internal queue fills and the item channel backs up.
  initial begin
    int gap;
    results.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap(take_burst);
      if (taken == 150) gap = 300;
      if (gap > 0) begin
        results.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      results.ready <= 1'b1;
      do @(posedge clk); while (!results.valid);
      taken++;
    end
  end

  initial begin
    logic signed [SkipSetW-1:0] mode;
    logic [15:0]                fps;
    logic [SkipW-1:0]           floor_skip;
    logic [15:0]                eval_ms;
    logic [15:0]                hold_ms;
    logic [ElapsedW-1:0]        us;
    logic [TimeW-1:0]           stamp;
    int unsigned                load_us;

    items.valid      <= 1'b0;
    items.kind       <= KindSample;
    items.elapsed_us <= '0;
    items.now_ms     <= '0;
    cfg.valid        <= 1'b0;
    cfg.index        <= REG_SKIP_SETTING;
    cfg.data         <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // After reset the controller is disabled; a zero sample keeps the
    // average at zero for the zero-average case below.
    send_item(KindEval, '1, '1);
    send_item(KindSample, '0, '0);
    drain;

    // Automatic mode at 30 fps with the shortest intervals. The first
    // evaluation only starts the timers; the next one wraps around the top
    // of the time range and is due while the average is still zero.
    configure(9'sd0, 16'd7680, 8'd0, 16'd1, 16'd1);
    send_item(KindEval, 24'hABCDEF, 48'hFFFF_FFFF_FFF0);
    send_item(KindEval, 24'h123456, 48'd5);
    send_item(KindSample, 24'hFFFFFF, 48'h5555_5555_5555);
    // Huge average: the needed count is clamped to fps-1 and raised at once.
    send_item(KindEval, '0, 48'd10);
    send_item(KindEval, '0, 48'd11);
    send_item(KindSample, 24'd0, 48'hAAAA_AAAA_AAAA);
    drain;

    // A lower rate brings the target down; the count steps down by skip/5.
    configure(9'sd0, 16'd2560, 8'd0, 16'd1, 16'd1);
    send_item(KindEval, '0, 48'd20);
    send_item(KindEval, '0, 48'd30);
    drain;

    // Zero output rate: a due evaluation only moves the check timer.
    configure(9'sd0, 16'd0, 8'd0, 16'd1, 16'd1);
    send_item(KindEval, '0, 48'd40);
    drain;

    // Below one frame per second the clamp gives -1, so the lowering path
    // runs and the floor lifts the result to the highest minimum.
    configure(9'sd0, 16'd100, 8'd255, 16'd1, 16'd1);
    send_item(KindEval, '0, 48'd50);
    send_item(KindEval, '0, 48'd60);
    drain;

    // Register maxima: only a gap above 65535 ms makes an evaluation due.
    configure(9'sd0, 16'hFFFF, 8'd255, 16'hFFFF, 16'hFFFF);
    send_item(KindEval, '0, 48'd70);
    send_item(KindEval, '0, 48'd65606);
    drain;

    // Fixed counts at both ends, then the most negative setting.
    configure(9'sd255, RstOutputFps, RstMinSkip, RstEvalMs, RstHoldMs);
    send_item(KindEval, '0, 48'd70000);
    drain;
    configure(9'sd1, RstOutputFps, RstMinSkip, RstEvalMs, RstHoldMs);
    send_item(KindEval, '0, 48'd70001);
    drain;
    configure(-9'sd256, RstOutputFps, RstMinSkip, RstEvalMs, RstHoldMs);
    send_item(KindEval, '0, 48'd70002);
    send_item(KindSample, 24'd1000, '0);
    drain;

    // Random part: each phase picks a register setting, mostly automatic
    // mode, then streams samples and evaluations with a roughly monotonic
    // clock. The sample level drifts so the count is raised and lowered.
    stamp   = 48'd100000;
    load_us = 33000;
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 9))
        7:       mode = SkipSetW'($urandom_range(1, 255));
        8:       mode = -SkipSetW'($urandom_range(1, 256));
        default: mode = 9'sd0;
      endcase
      case ($urandom_range(0, 5))
        0:       fps = 16'd7680;
        1:       fps = 16'd15360;
        2:       fps = 16'($urandom_range(256, 2560));
        3:       fps = 16'($urandom_range(0, 65535));
        4:       fps = 16'hFFFF;
        default: fps = 16'($urandom_range(0, 255));
      endcase
      floor_skip = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 4));
      eval_ms = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(1, 30));
      hold_ms = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(1, 80));
      configure(mode, fps, floor_skip, eval_ms, hold_ms);

      for (int n = 0; n < 115; n++) begin
        if ($urandom_range(0, 24) == 0) load_us = $urandom_range(0, 600000);
        if ($urandom_range(0, 9) < 6) begin
          case ($urandom_range(0, 49))
            0:       us = '1;
            1, 2, 3: us = 24'($urandom);
            default: us = 24'($urandom_range(load_us / 2, load_us + load_us / 2));
          endcase
          send_item(KindSample, us, TimeW'({$urandom, $urandom}));
        end else begin
          if ($urandom_range(0, 29) == 0)
            stamp = TimeW'({$urandom, $urandom});
          else
            stamp = stamp + $urandom_range(0, 2 * eval_ms + 2);
          send_item(KindEval, 24'($urandom), stamp);
        end
      end
      drain;
    end

    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
